// ----- hw/rtl/dsb_pkg.sv -----
// shared types, constants and helpers for the depth sort block
// depends on nothing; imported by every module of the block
`default_nettype none
package dsb_pkg;
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int LG_MAX   = ADDR_W;
	localparam int LG_W     = $clog2(LG_MAX + 1);
	localparam int COORD_W  = 20;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int IDX_W    = 20;
	localparam int KEY_W    = 42;
	localparam int RANK_W   = KEY_W + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		CFG_CAMERA_X = 2'd0,
		CFG_CAMERA_Y = 2'd1,
		CFG_CAMERA_Z = 2'd2
	} cfg_idx_e;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [IDX_W-1:0]          vertex_index;
		logic                      set_end;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] sorted_index;
		logic [KEY_W-1:0] distance_sq;
		logic             run_end;
		logic             truncated;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
		logic             set_end;
	} qent_t;

	// smallest l with 2**l >= n
	function automatic logic [LG_W-1:0] span_lg(input logic [CNT_W-1:0] n);
		logic [LG_W-1:0] res;
		res = LG_W'(LG_MAX);
		for (int l = LG_MAX; l >= 0; l--) begin
			if ((CNT_W'(1) << l) >= n) res = LG_W'(l);
		end
		return res;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/dsb_front.sv -----
// front end: camera registers and the squared distance pipeline
// depends on dsb_pkg
`default_nettype none
module dsb_front import dsb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [COORD_W-1:0] cfg_data,
	input  wire logic               push,
	output logic                    full,
	input  wire item_t              item,
	output logic                    q_push,
	input  wire logic               q_full,
	output qent_t                   q_data
);
	logic signed [COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic [DIFF_W-1:0] ax_s1, ay_s1, az_s1;
	logic [KEY_W-1:0]  sx_s2, sy_s2, sz_s2, sum_s3;
	logic [IDX_W-1:0]  idx_s1, idx_s2, idx_s3;
	logic              end_s1, end_s2, end_s3;
	logic              v_s1, v_s2, v_s3;
	logic              advance;
	logic signed [DIFF_W-1:0] dx, dy, dz;

	assign cfg_ready = 1'b1;
	assign advance   = !v_s3 || !q_full;
	assign full      = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_e'(cfg_index))
				CFG_CAMERA_X: cam_x_q <= cfg_data;
				CFG_CAMERA_Y: cam_y_q <= cfg_data;
				CFG_CAMERA_Z: cam_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dx = DIFF_W'(item.pos_x) - DIFF_W'(cam_x_q);
	assign dy = DIFF_W'(item.pos_y) - DIFF_W'(cam_y_q);
	assign dz = DIFF_W'(item.pos_z) - DIFF_W'(cam_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ax_s1  <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
			ay_s1  <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
			az_s1  <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
			idx_s1 <= item.vertex_index;
			end_s1 <= item.set_end;
			sx_s2  <= KEY_W'(ax_s1) * KEY_W'(ax_s1);
			sy_s2  <= KEY_W'(ay_s1) * KEY_W'(ay_s1);
			sz_s2  <= KEY_W'(az_s1) * KEY_W'(az_s1);
			idx_s2 <= idx_s1;
			end_s2 <= end_s1;
			sum_s3 <= sx_s2 + sy_s2 + sz_s2;
			idx_s3 <= idx_s2;
			end_s3 <= end_s2;
		end
	end

	assign q_push = v_s3 && !q_full;
	assign q_data = '{key: sum_s3, idx: idx_s3, set_end: end_s3};
endmodule
`default_nettype wire

// ----- hw/rtl/dsb_queue.sv -----
// short queue between the key pipeline and the sorter
// depends on dsb_pkg
`default_nettype none
module dsb_queue import dsb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr,
	input  wire qent_t wdata,
	output logic       q_full,
	input  wire logic  rd,
	output logic       q_empty,
	output qent_t      rdata
);
	qent_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign q_full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 1'b1;
			if (rd) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wdata;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/dsb_back.sv -----
// back end: entry store, bitonic compare passes and result emission
// depends on dsb_pkg
`default_nettype none
module dsb_back import dsb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_empty,
	input  wire qent_t q_data,
	output logic       q_pop,
	output logic       empty,
	input  wire logic  pop,
	output result_t    result
);
	back_state_t       state_q, state_nx;
	logic [RANK_W-1:0] rank_q [CAPACITY];
	logic [IDX_W-1:0]  idx_q  [CAPACITY];
	logic [RANK_W-1:0] rank_nx [CAPACITY];
	logic [IDX_W-1:0]  idx_nx  [CAPACITY];
	logic [CNT_W-1:0]  fill_q, fill_nx, n_q, cnt_q;
	logic              ovf_q;
	logic [LG_W-1:0]   lg_q, k_q, j_q;
	logic              out_v_q;
	result_t           out_q;
	logic              out_load;
	logic [ADDR_W-1:0] epos;
	logic              store;

	assign q_pop    = (state_q == ST_COLLECT) && !q_empty;
	assign store    = q_pop && (fill_q < CNT_W'(CAPACITY));
	assign fill_nx  = fill_q + CNT_W'(store);
	assign out_load = (state_q == ST_EMIT) && (!out_v_q || pop);
	assign epos     = ADDR_W'((CNT_W'(1) << lg_q) - CNT_W'(1) - cnt_q);
	assign empty    = !out_v_q;
	assign result   = out_q;

	// one compare pass, all pairs in parallel
	always_comb begin
		logic [ADDR_W-1:0] p, jbit;
		logic [CNT_W-1:0]  kbit;
		logic              lower, up, swp;
		logic [RANK_W-1:0] a, b;
		jbit = ADDR_W'(1) << j_q;
		kbit = CNT_W'(1) << k_q;
		for (int i = 0; i < CAPACITY; i++) begin
			p     = ADDR_W'(i) ^ jbit;
			lower = ((ADDR_W'(i) & jbit) == '0);
			up    = ((CNT_W'(i) & kbit) == '0);
			a     = lower ? rank_q[i] : rank_q[p];
			b     = lower ? rank_q[p] : rank_q[i];
			swp   = up ? (a > b) : (a < b);
			rank_nx[i] = swp ? rank_q[p] : rank_q[i];
			idx_nx[i]  = swp ? idx_q[p]  : idx_q[i];
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_COLLECT: if (q_pop && q_data.set_end) state_nx = ST_LOAD;
			ST_LOAD:    state_nx = (lg_q == '0) ? ST_EMIT : ST_SORT;
			ST_SORT:    if (j_q == '0 && k_q == lg_q) state_nx = ST_EMIT;
			ST_EMIT:    if (out_load && cnt_q == n_q - CNT_W'(1)) state_nx = ST_COLLECT;
			default:    state_nx = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_COLLECT;
		else         state_q <= state_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			n_q     <= '0;
			lg_q    <= '0;
			k_q     <= '0;
			j_q     <= '0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load)  out_v_q <= 1'b1;
			else if (pop)  out_v_q <= 1'b0;
			case (state_q)
				ST_COLLECT: begin
					if (q_pop) begin
						fill_q <= fill_nx;
						if (!store) ovf_q <= 1'b1;
						if (q_data.set_end) begin
							n_q  <= fill_nx;
							lg_q <= span_lg(fill_nx);
						end
					end
				end
				ST_LOAD: begin
					k_q   <= LG_W'(1);
					j_q   <= '0;
					cnt_q <= '0;
				end
				ST_SORT: begin
					if (j_q == '0) begin
						k_q <= k_q + LG_W'(1);
						j_q <= k_q;
					end else begin
						j_q <= j_q - LG_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == n_q - CNT_W'(1)) begin
							fill_q <= '0;
							ovf_q  <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_COLLECT: begin
				if (store) begin
					rank_q[fill_q[ADDR_W-1:0]] <= RANK_W'(q_data.key) + RANK_W'(1);
					idx_q[fill_q[ADDR_W-1:0]]  <= q_data.idx;
				end
			end
			ST_LOAD: begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (CNT_W'(i) >= n_q) rank_q[i] <= '0;
				end
			end
			ST_SORT: begin
				rank_q <= rank_nx;
				idx_q  <= idx_nx;
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.sorted_index <= idx_q[epos];
			out_q.distance_sq  <= KEY_W'(rank_q[epos] - RANK_W'(1));
			out_q.run_end      <= (cnt_q == n_q - CNT_W'(1));
			out_q.truncated    <= ovf_q;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/depth_sort_bitonic.sv -----
// top level of the depth sort: key front end, queue and bitonic back end
// depends on dsb_pkg, dsb_front, dsb_queue, dsb_back
//
// channel   | handshake             | payload
// ----------+-----------------------+--------------------------
// input     | push / full           | item (item_t)
// results   | empty / pop           | result (result_t)
// config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// keys leave a three-stage multiply pipeline, one per cycle while the four-entry queue has room
// the sorter stores one entry per cycle while the queue holds entries, then spends a load
// step and L*(L+1)/2 compare passes (L = log2 of the padded set size, so at most 21
// passes for 64 entries), and emits one result whenever the result register is free or popped
// input stalls (full) only while the queue is full and a key waits in the last pipeline stage
// reset clears control state and the camera registers; stored entries are not cleared
`default_nettype none
module depth_sort_bitonic import dsb_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire item_t              item,
	output logic                    empty,
	input  wire logic               pop,
	output result_t                 result,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [COORD_W-1:0] cfg_data
);
	logic  q_wr, q_full, q_rd, q_empty;
	qent_t q_wdata, q_rdata;

	// key computation and camera registers
	dsb_front u_front (
		.clk, .arst_n,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.push, .full, .item,
		.q_push(q_wr), .q_full, .q_data(q_wdata)
	);

	// decoupling queue, lets the front run on until the queue fills while the back sorts or emits
	dsb_queue u_queue (
		.clk, .arst_n,
		.wr(q_wr), .wdata(q_wdata), .q_full,
		.rd(q_rd), .q_empty, .rdata(q_rdata)
	);

	// entry store, sort passes, result register
	dsb_back u_back (
		.clk, .arst_n,
		.q_empty, .q_data(q_rdata), .q_pop(q_rd),
		.empty, .pop, .result
	);
endmodule
`default_nettype wire

// ----- hw/rtl/dsb_checker.sv -----
// port-level checks on the depth sort top level, bound in below
// depends on dsb_pkg and depth_sort_bitonic
`default_nettype none
module dsb_checker import dsb_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               empty,
	input wire logic               pop,
	input wire result_t            result
);
	logic             in_run_q;
	logic [KEY_W-1:0] prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q <= 1'b0;
			prev_q   <= '0;
		end else if (pop && !empty) begin
			in_run_q <= !result.run_end;
			prev_q   <= result.distance_sq;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty) else $error("result withdrawn");
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(result)) else $error("result changed while stalled");
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.distance_sq <= (KEY_W'(3) << 40))) else $error("key out of range");
	a_far_first: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && in_run_q) |-> (result.distance_sq <= prev_q))
		else $error("results not farthest first");
endmodule

bind depth_sort_bitonic dsb_checker u_chk (.*);
`default_nettype wire
